@@ hw/rtl/ihpf_pkg.sv @@
// ihpf_pkg: shared types and constants for the header parser and flow hash
// used by the controller, the datapath and the top level
`default_nettype none
package ihpf_pkg;
    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam logic [15:0] VLAN_TYPE  = 16'h8100;
    localparam logic [15:0] IPV4_TYPE  = 16'h0800;
    localparam logic [5:0]  MIN_IP_HDR = 6'd20;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [3:0]  HASH_LAST  = 4'd10;

    typedef struct packed {
        logic       capture;
        logic       check;
        logic       hash;
        logic       clear;
        logic [3:0] step;
    } t_cmd;

    typedef struct packed {
        logic drop;
    } t_sts;
endpackage
`default_nettype wire

@@ hw/rtl/ihpf_if.sv @@
// ihpf_in_if / ihpf_out_if: valid-ready channels for packet bytes and results
// no dependencies
`default_nettype none
interface ihpf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ihpf_out_if;
    logic        valid;
    logic        ready;
    logic        drop;
    logic [4:0]  l3_pos;
    logic [7:0]  ip_protocol;
    logic [6:0]  l4_pos;
    logic [7:0]  data_pos;
    logic [31:0] tuple_hash;
    modport source (output valid, drop, l3_pos, ip_protocol, l4_pos,
                    data_pos, tuple_hash, input ready);
    modport sink   (input valid, drop, l3_pos, ip_protocol, l4_pos,
                    data_pos, tuple_hash, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ipv4_header_parse_flow_hash_unit.sv @@
// ipv4_header_parse_flow_hash_unit: top level joining controller and datapath
// depends on ihpf_pkg, ihpf_if, ihpf_ctrl, ihpf_dp
// Packet bytes are taken one per cycle while a packet is being received. After
// the last byte the unit runs the header checks in one state and, unless the
// packet is dropped, the hash in eleven steps (one shared 32-bit multiply per
// step), then holds the result until it is taken. No bytes of the next packet
// are accepted until the result has been taken.
`default_nettype none
module ipv4_header_parse_flow_hash_unit (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    ihpf_in_if.sink    i_in,
    ihpf_out_if.source o_out
);
    import ihpf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ihpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_byte),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    ihpf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .o_sts         (sts),
        .o_drop        (o_out.drop),
        .o_l3_pos      (o_out.l3_pos),
        .o_ip_protocol (o_out.ip_protocol),
        .o_l4_pos      (o_out.l4_pos),
        .o_data_pos    (o_out.data_pos),
        .o_tuple_hash  (o_out.tuple_hash)
    );
endmodule
`default_nettype wire

@@ hw/rtl/ihpf_ctrl.sv @@
// ihpf_ctrl: state machine sequencing byte capture, checks, hash steps, output
// depends on ihpf_pkg
`default_nettype none
module ihpf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    input  wire logic          i_out_ready,
    input  wire ihpf_pkg::t_sts i_sts,
    output ihpf_pkg::t_cmd     o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import ihpf_pkg::*;

    localparam logic [1:0] S_RX   = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_HASH = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [3:0] r_step, n_step;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.step   = r_step;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        unique case (r_state)
            S_RX: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.check = 1'b1;
                n_step      = '0;
                n_state     = i_sts.drop ? S_OUT : S_HASH;
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_step     = r_step + 4'd1;
                if (r_step == HASH_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_RX;
                end
            end
            default: n_state = S_RX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ihpf_dp.sv @@
// ihpf_dp: header field capture, packet checks, offsets and fnv-1a hash unit
// depends on ihpf_pkg
`default_nettype none
module ihpf_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ihpf_pkg::t_cmd i_cmd,
    input  wire logic [7:0]     i_data_byte,
    output ihpf_pkg::t_sts      o_sts,
    output logic                o_drop,
    output logic [4:0]          o_l3_pos,
    output logic [7:0]          o_ip_protocol,
    output logic [6:0]          o_l4_pos,
    output logic [7:0]          o_data_pos,
    output logic [31:0]         o_tuple_hash
);
    import ihpf_pkg::*;

    logic [7:0]  r_count;
    logic [15:0] r_ether;
    logic        r_vlan;
    logic [7:0]  r_ipvl;
    logic [15:0] r_frag;
    logic [7:0]  r_proto;
    logic [31:0] r_saddr, r_daddr;
    logic [15:0] r_sport, r_dport;
    logic [3:0]  r_tdo;
    logic [15:0] r_sp_sel, r_dp_sel;
    logic [31:0] r_hash;

    logic [7:0]  b;
    logic [4:0]  n_cur;
    logic [7:0]  rel, tpos;
    logic [5:0]  ihl_cur;

    assign b       = i_data_byte;
    assign n_cur   = r_vlan ? 5'd18 : 5'd14;
    assign rel     = r_count - {3'd0, n_cur};
    assign ihl_cur = {r_ipvl[3:0], 2'b00};
    assign tpos    = rel - {2'd0, ihl_cur};

    // packet checks on the captured header
    logic [8:0] len;
    logic [6:0] t_off;
    logic [7:0] pay;
    logic       drop, use_ports;

    assign len   = {1'b0, r_count};
    assign t_off = {2'd0, n_cur} + {1'b0, ihl_cur};

    always_comb begin
        drop      = 1'b0;
        use_ports = 1'b0;
        pay       = {1'b0, t_off};
        if (len < 9'd14 || r_ether != IPV4_TYPE) begin
            drop = 1'b1;
        end else if (len < {4'd0, n_cur} + {3'd0, MIN_IP_HDR}) begin
            drop = 1'b1;
        end else if (r_ipvl[7:4] != 4'd4) begin
            drop = 1'b1;
        end else if (ihl_cur < MIN_IP_HDR || len < {2'd0, t_off}) begin
            drop = 1'b1;
        end else if (r_frag[13:0] != 14'd0) begin
            drop = 1'b1;
        end else if (r_proto == PROTO_TCP) begin
            if (len < {2'd0, t_off} + 9'd20) begin
                drop = 1'b1;
            end else begin
                use_ports = 1'b1;
                pay       = {1'b0, t_off} + {2'd0, r_tdo, 2'b00};
            end
        end else if (r_proto == PROTO_UDP) begin
            if (len < {2'd0, t_off} + 9'd8) begin
                drop = 1'b1;
            end else begin
                use_ports = 1'b1;
                pay       = {1'b0, t_off} + 8'd8;
            end
        end
    end

    assign o_sts.drop = drop;

    // hash operand for the current step
    logic [31:0] hv;
    always_comb begin
        case (i_cmd.step)
            4'd0:    hv = {24'd0, r_saddr[7:0]};
            4'd1:    hv = {24'd0, r_saddr[15:8]};
            4'd2:    hv = {24'd0, r_saddr[23:16]};
            4'd3:    hv = {24'd0, r_saddr[31:24]};
            4'd4:    hv = {24'd0, r_daddr[7:0]};
            4'd5:    hv = {24'd0, r_daddr[15:8]};
            4'd6:    hv = {24'd0, r_daddr[23:16]};
            4'd7:    hv = {24'd0, r_daddr[31:24]};
            4'd8:    hv = {16'd0, r_sp_sel};
            4'd9:    hv = {16'd0, r_dp_sel};
            default: hv = {24'd0, r_proto};
        endcase
    end

    logic [31:0] hmul;
    assign hmul = (r_hash ^ hv) * FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            r_ether <= '0;
            r_vlan  <= 1'b0;
            r_ipvl  <= '0;
            r_frag  <= '0;
            r_proto <= '0;
            r_saddr <= '0;
            r_daddr <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_tdo   <= '0;
        end else if (i_cmd.capture) begin
            r_count <= (r_count == 8'd255) ? r_count : r_count + 8'd1;
            if (r_count == 8'd12) begin
                r_ether <= {b, 8'd0};
            end
            if (r_count == 8'd13) begin
                r_ether <= r_ether | {8'd0, b};
                if ((r_ether | {8'd0, b}) == VLAN_TYPE) begin
                    r_vlan <= 1'b1;
                end
            end else begin
                if (r_vlan && r_count == 8'd16) begin
                    r_ether <= {b, 8'd0};
                end
                if (r_vlan && r_count == 8'd17) begin
                    r_ether <= r_ether | {8'd0, b};
                end
                if (r_count >= {3'd0, n_cur}) begin
                    if (rel == 8'd0) begin
                        r_ipvl <= b;
                    end else begin
                        if (rel == 8'd6) begin
                            r_frag[15:8] <= b;
                        end
                        if (rel == 8'd7) begin
                            r_frag[7:0] <= b;
                        end
                        if (rel == 8'd9) begin
                            r_proto <= b;
                        end
                        if (rel >= 8'd12 && rel < 8'd16) begin
                            r_saddr <= {r_saddr[23:0], b};
                        end
                        if (rel >= 8'd16 && rel < 8'd20) begin
                            r_daddr <= {r_daddr[23:0], b};
                        end
                        if (ihl_cur >= MIN_IP_HDR && rel >= {2'd0, ihl_cur}) begin
                            if (tpos < 8'd2) begin
                                r_sport <= {r_sport[7:0], b};
                            end else if (tpos < 8'd4) begin
                                r_dport <= {r_dport[7:0], b};
                            end else if (tpos == 8'd12) begin
                                r_tdo <= b[7:4];
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            o_drop        <= drop;
            o_l3_pos      <= drop ? 5'd0 : n_cur;
            o_ip_protocol <= drop ? 8'd0 : r_proto;
            o_l4_pos      <= drop ? 7'd0 : t_off;
            o_data_pos    <= drop ? 8'd0 : pay;
            r_sp_sel      <= use_ports ? r_sport : 16'd0;
            r_dp_sel      <= use_ports ? r_dport : 16'd0;
            r_hash        <= drop ? 32'd0 : FNV_BASIS;
        end else if (i_cmd.hash) begin
            r_hash <= hmul;
        end
    end

    assign o_tuple_hash = r_hash;
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for the ipv4 header parser and flow hash unit
// depends on ihpf_pkg, ihpf_if and ipv4_header_parse_flow_hash_unit
// packets are built as byte requests, predicted in-bench and results compared in order
`default_nettype none
module tb_top;
    import ihpf_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte_req;

    typedef struct packed {
        logic        drop;
        logic [4:0]  l3_pos;
        logic [7:0]  ip_protocol;
        logic [6:0]  l4_pos;
        logic [7:0]  data_pos;
        logic [31:0] tuple_hash;
    } t_parse_res;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    ihpf_in_if  in_ch();
    ihpf_out_if out_ch();

    ipv4_header_parse_flow_hash_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_byte_req  byte_q[$];
    t_parse_res parse_q[$];

    // predictor state
    logic [7:0]  p_count;
    logic [15:0] p_kind;
    logic        p_vlan;
    logic [7:0]  p_verlen;
    logic [15:0] p_frag;
    logic [7:0]  p_proto;
    logic [31:0] p_saddr;
    logic [31:0] p_daddr;
    logic [15:0] p_sport;
    logic [15:0] p_dport;
    logic [3:0]  p_tcpoff;

    int n_fail;
    int n_shown;
    int n_packets;
    int n_items;
    int n_results;
    int n_kept;
    int idle_cycles;
    bit no_idle;
    bit hold_rx;
    bit in_taken;
    int tx_gap;
    int rx_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] fnv_step(logic [31:0] h, logic [31:0] v);
        return (h ^ v) * FNV_PRIME;
    endfunction

    function automatic logic [31:0] fnv_word(logic [31:0] h, logic [31:0] w);
        logic [31:0] acc;
        acc = h;
        for (int i = 0; i < 4; i++) acc = fnv_step(acc, {24'd0, w[8*i +: 8]});
        return acc;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic clear_parse_state();
        p_count = '0; p_kind = '0; p_vlan = 1'b0; p_verlen = '0; p_frag = '0;
        p_proto = '0; p_saddr = '0; p_daddr = '0; p_sport = '0; p_dport = '0;
        p_tcpoff = '0;
    endtask

    task automatic predict_byte(t_byte_req rq);
        int pos, n, r, ihl, t, len, pay;
        logic [7:0] b;
        logic drop;
        logic [15:0] sp, dp;
        logic [31:0] h;
        t_parse_res res;
        b = rq.data_byte;
        pos = p_count;
        n = p_vlan ? 18 : 14;
        if (pos == 12) p_kind = {b, 8'd0};
        if (pos == 13) begin
            p_kind[7:0] = b;
            if (p_kind == VLAN_TYPE) p_vlan = 1'b1;
        end else begin
            if (p_vlan && pos == 16) p_kind = {b, 8'd0};
            if (p_vlan && pos == 17) p_kind[7:0] = b;
            if (pos >= n) begin
                r = pos - n;
                if (r == 0) begin
                    p_verlen = b;
                end else begin
                    if (r == 6) p_frag[15:8] = b;
                    if (r == 7) p_frag[7:0] = b;
                    if (r == 9) p_proto = b;
                    if (r >= 12 && r < 16) p_saddr = {p_saddr[23:0], b};
                    if (r >= 16 && r < 20) p_daddr = {p_daddr[23:0], b};
                    ihl = p_verlen[3:0] * 4;
                    if (ihl >= MIN_IP_HDR && r >= ihl) begin
                        t = r - ihl;
                        if (t < 2) p_sport = {p_sport[7:0], b};
                        else if (t < 4) p_dport = {p_dport[7:0], b};
                        else if (t == 12) p_tcpoff = b[7:4];
                    end
                end
            end
        end
        if (p_count != 8'd255) p_count = p_count + 8'd1;
        if (!rq.last_byte) return;
        len = pos + 1;
        n = p_vlan ? 18 : 14;
        ihl = p_verlen[3:0] * 4;
        t = n + ihl;
        pay = t;
        sp = '0;
        dp = '0;
        drop = 1'b0;
        if (len < 14 || p_kind != IPV4_TYPE) drop = 1'b1;
        else if (len < n + MIN_IP_HDR) drop = 1'b1;
        else if (p_verlen[7:4] != 4'd4) drop = 1'b1;
        else if (ihl < MIN_IP_HDR || len < t) drop = 1'b1;
        else if (p_frag[13:0] != 14'd0) drop = 1'b1;
        else if (p_proto == PROTO_TCP) begin
            if (len < t + 20) drop = 1'b1;
            else begin
                sp = p_sport; dp = p_dport; pay = t + p_tcpoff * 4;
            end
        end else if (p_proto == PROTO_UDP) begin
            if (len < t + 8) drop = 1'b1;
            else begin
                sp = p_sport; dp = p_dport; pay = t + 8;
            end
        end
        res = '0;
        res.drop = drop;
        if (!drop) begin
            h = fnv_word(FNV_BASIS, p_saddr);
            h = fnv_word(h, p_daddr);
            h = fnv_step(h, {16'd0, sp});
            h = fnv_step(h, {16'd0, dp});
            h = fnv_step(h, {24'd0, p_proto});
            res.l3_pos = n[4:0];
            res.ip_protocol = p_proto;
            res.l4_pos = t[6:0];
            res.data_pos = pay[7:0];
            res.tuple_hash = h;
        end
        parse_q.push_back(res);
        clear_parse_state();
    endtask

    // packet builder: well formed headers with random content, then faults
    task automatic build_packet(int vlan, int ihl_w, int proto, int fault, int tail);
        logic [7:0] pkt[$];
        int hdr, ip_len, l4, total;
        logic [7:0] b;
        for (int i = 0; i < 12; i++) pkt.push_back(rand_byte());
        if (vlan) begin
            pkt.push_back(8'h81); pkt.push_back(8'h00);
            pkt.push_back(rand_byte()); pkt.push_back(rand_byte());
        end
        pkt.push_back(fault == 1 ? rand_byte() : 8'h08);
        pkt.push_back(fault == 1 ? rand_byte() : 8'h00);
        hdr = pkt.size();
        ip_len = ihl_w * 4;
        for (int i = 0; i < ip_len; i++) pkt.push_back(rand_byte());
        pkt[hdr] = {(fault == 2 ? 4'($urandom_range(0, 15)) : 4'd4), 4'(ihl_w)};
        b = rand_byte();
        pkt[hdr + 6] = (fault == 3) ? b : {b[7:6] & 2'b10, 6'd0};
        pkt[hdr + 7] = (fault == 3) ? rand_byte() : 8'd0;
        pkt[hdr + 9] = 8'(proto);
        l4 = (proto == PROTO_TCP) ? 20 : (proto == PROTO_UDP ? 8 : 0);
        for (int i = 0; i < l4; i++) pkt.push_back(rand_byte());
        for (int i = 0; i < tail; i++) pkt.push_back(rand_byte());
        total = pkt.size();
        if (fault == 4) total = $urandom_range(1, total);
        for (int i = 0; i < total; i++) begin
            t_byte_req rq;
            rq.data_byte = pkt[i];
            rq.last_byte = (i == total - 1);
            byte_q.push_back(rq);
            n_items++;
        end
        n_packets++;
    endtask

    task automatic build_noise(int len);
        for (int i = 0; i < len; i++) begin
            t_byte_req rq;
            rq.data_byte = rand_byte();
            rq.last_byte = (i == len - 1);
            byte_q.push_back(rq);
            n_items++;
        end
        n_packets++;
    endtask

    function automatic int rand_proto();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) return PROTO_TCP;
        if (k < 8) return PROTO_UDP;
        return $urandom_range(0, 255);
    endfunction

    // request taken at the last rising edge
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
        end else begin
            if (in_ch.valid) void'(byte_q.pop_front());
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                if (!no_idle && $urandom_range(0, 15) == 0) begin
                    tx_gap <= $urandom_range(0, 6);
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= byte_q[0].data_byte;
                    in_ch.last_byte <= byte_q[0].last_byte;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver readiness
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            out_ch.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            out_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // long receiver hold so the unit back-pressures its input
    initial begin
        hold_rx = 1'b0;
        wait (i_rst_n === 1'b1);
        hold_rx = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                t_byte_req rq;
                rq.data_byte = in_ch.data_byte;
                rq.last_byte = in_ch.last_byte;
                predict_byte(rq);
            end
            if (out_ch.valid && out_ch.ready) begin
                t_parse_res got, exp_r;
                got.drop = out_ch.drop;
                got.l3_pos = out_ch.l3_pos;
                got.ip_protocol = out_ch.ip_protocol;
                got.l4_pos = out_ch.l4_pos;
                got.data_pos = out_ch.data_pos;
                got.tuple_hash = out_ch.tuple_hash;
                n_results++;
                if (parse_q.size() == 0) begin
                    n_fail++;
                    if (n_shown < 10) begin
                        n_shown++;
                        $display("unexpected result drop=%0d hash=%08h", got.drop,
                                 got.tuple_hash);
                    end
                end else begin
                    exp_r = parse_q.pop_front();
                    if (!exp_r.drop) n_kept++;
                    if (got !== exp_r) begin
                        n_fail++;
                        if (n_shown < 10) begin
                            n_shown++;
                            $display("mismatch exp drop=%0d net=%0d proto=%0d tr=%0d pay=%0d h=%08h",
                                     exp_r.drop, exp_r.l3_pos, exp_r.ip_protocol,
                                     exp_r.l4_pos, exp_r.data_pos,
                                     exp_r.tuple_hash);
                            $display("         got drop=%0d net=%0d proto=%0d tr=%0d pay=%0d h=%08h",
                                     got.drop, got.l3_pos, got.ip_protocol,
                                     got.l4_pos, got.data_pos,
                                     got.tuple_hash);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || hold_rx) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stalled after %0d packets, %0d results", n_packets, n_results);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        n_fail = 0; n_shown = 0; n_packets = 0; n_items = 0; n_results = 0; n_kept = 0;
        idle_cycles = 0; tx_gap = 0; rx_gap = 0;
        no_idle = 1'b0; in_taken = 1'b0;
        clear_parse_state();

        // directed packets
        build_packet(0, 5, PROTO_TCP, 0, 0);
        build_packet(1, 5, PROTO_UDP, 0, 3);
        build_packet(0, 15, PROTO_TCP, 0, 2);
        build_packet(1, 15, PROTO_UDP, 0, 0);
        build_packet(0, 5, 1, 0, 0);
        build_packet(0, 5, 255, 0, 0);
        build_packet(0, 5, 0, 0, 5);
        build_packet(0, 4, PROTO_TCP, 0, 0);
        build_packet(0, 0, PROTO_UDP, 0, 20);
        build_packet(0, 5, PROTO_TCP, 1, 0);
        build_packet(0, 5, PROTO_TCP, 2, 0);
        build_packet(0, 5, PROTO_UDP, 3, 0);
        build_packet(1, 5, PROTO_TCP, 4, 0);
        build_packet(1, 5, PROTO_UDP, 4, 0);
        build_packet(0, 5, PROTO_UDP, 0, 230);
        build_noise(1);
        build_noise(13);
        build_noise(40);
        for (int k = 0; k < 16; k++) begin
            t_byte_req rq;
            rq.data_byte = (k == 12) ? 8'h81 : ((k == 13) ? 8'h00 : 8'hFF);
            rq.last_byte = (k == 15);
            byte_q.push_back(rq);
            n_items++;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // random packets, mostly well formed
        while (n_items < 1500) begin
            int fault;
            fault = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4);
            if ($urandom_range(0, 19) == 0)
                build_noise($urandom_range(1, 40));
            else
                build_packet($urandom_range(0, 1), $urandom_range(0, 9) < 7 ? 5 :
                             $urandom_range(0, 15), rand_proto(), fault,
                             $urandom_range(0, 9) == 0 ? $urandom_range(0, 200) :
                             $urandom_range(0, 8));
            while (byte_q.size() > 4000) @(posedge i_clk);
        end
        while (byte_q.size() > 150) @(posedge i_clk);
        no_idle = 1'b1;
        while (byte_q.size() > 0) @(posedge i_clk);
        while (parse_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d packets in %0d byte requests, %0d results, %0d kept and hashed",
                 n_packets, n_items, n_results, n_kept);
        if (n_fail == 0 && parse_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("mismatches: %0d, outstanding: %0d", n_fail, parse_q.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
